@@ rtl/bts_pkg.sv @@
// ----------------------------------------------------------------------------
// bts_pkg
// Shared constants, types and helpers of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int MaxW       = 256;
  localparam int MaxH       = 256;
  localparam int FracBits   = 16;
  localparam int CoordBits  = 32;
  localparam int ColBits    = $clog2(MaxW);
  localparam int RowBits    = $clog2(MaxH);
  localparam int AddrBits   = ColBits + RowBits;
  localparam int Depth      = MaxW * MaxH;
  localparam int SizeBits   = 9;
  localparam int ProdBits   = CoordBits + ColBits;
  localparam int WholeBits  = ProdBits - FracBits;
  localparam int ChanBits   = 8;
  localparam int RgbBits    = 3 * ChanBits;
  localparam int WtBits     = FracBits + 1;
  localparam int TopBits    = ChanBits + FracBits;
  localparam int AccBits    = TopBits + WtBits + 1;
  localparam int CfgIdxBits = 4;
  localparam int CfgDatBits = SizeBits;
  localparam int QDepth     = 4;
  localparam int QPtrBits   = $clog2(QDepth);

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_TEX_WIDTH  = 4'd0,
    CFG_TEX_HEIGHT = 4'd1
  } cfg_idx_t;

  typedef struct packed {
    kind_t                        kind;
    logic signed [WholeBits-1:0]  x0;
    logic        [FracBits-1:0]   fu;
    logic signed [WholeBits-1:0]  y0;
    logic        [FracBits-1:0]   fv;
    logic        [ColBits-1:0]    col;
    logic        [RowBits-1:0]    row;
    logic        [RgbBits-1:0]    rgb;
  } item_t;

  // Register value to usable size: zero counts as one, large values saturate.
  function automatic logic [SizeBits-1:0] eff_size(logic [SizeBits-1:0] r,
                                                   logic [SizeBits-1:0] mx);
    logic [SizeBits-1:0] s;
    if (r == '0) begin
      s = SizeBits'(1);
    end else if (r > mx) begin
      s = mx;
    end else begin
      s = r;
    end
    return s;
  endfunction

endpackage

@@ rtl/bts_if.sv @@
// ----------------------------------------------------------------------------
// bts interfaces
// Valid/ready channels for sample and write items, results and configuration.
// ----------------------------------------------------------------------------
interface bts_in_if;
  import bts_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic signed [CoordBits-1:0] tex_u;
  logic signed [CoordBits-1:0] tex_v;
  logic [ColBits-1:0]          write_col;
  logic [RowBits-1:0]          write_row;
  logic [RgbBits-1:0]          write_rgb;
  modport source (output valid, kind, tex_u, tex_v, write_col, write_row, write_rgb,
                  input ready);
  modport sink (input valid, kind, tex_u, tex_v, write_col, write_row, write_rgb,
                output ready);
endinterface

interface bts_out_if;
  import bts_pkg::*;
  logic                valid;
  logic                ready;
  logic [ChanBits-1:0] red;
  logic [ChanBits-1:0] green;
  logic [ChanBits-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface bts_cfg_if;
  import bts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CfgIdxBits-1:0] idx;
  logic [CfgDatBits-1:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

@@ rtl/bts_front.sv @@
// ----------------------------------------------------------------------------
// bts_front
// Accepts items, scales sample coordinates and splits them into texel index
// and fraction, then hands the item to the queue.
// ----------------------------------------------------------------------------
module bts_front (
  input  logic                          clk,
  input  logic                          rst_n,
  bts_in_if.sink                        in_if,
  input  logic [bts_pkg::SizeBits-1:0]  w_eff,
  input  logic [bts_pkg::SizeBits-1:0]  h_eff,
  input  logic                          q_full,
  output logic                          q_push,
  output bts_pkg::item_t                q_item
);
  import bts_pkg::*;

  logic                       s1_v_r;
  item_t                      s1_item_r;
  item_t                      s1_item_nxt;
  logic [ColBits-1:0]         wm1;
  logic [RowBits-1:0]         hm1;
  logic signed [ProdBits-1:0] pu;
  logic signed [ProdBits-1:0] pv;
  logic                       accept;

  assign q_push      = s1_v_r && !q_full;
  assign in_if.ready = !s1_v_r || !q_full;
  assign accept      = in_if.valid && in_if.ready;
  assign q_item      = s1_item_r;

  assign wm1 = ColBits'(w_eff - SizeBits'(1));
  assign hm1 = RowBits'(h_eff - SizeBits'(1));

  // Arithmetic shift of the product is the floor; the low bits are the fraction.
  assign pu = ProdBits'(in_if.tex_u) * ProdBits'($signed({1'b0, wm1}));
  assign pv = ProdBits'(in_if.tex_v) * ProdBits'($signed({1'b0, hm1}));

  always_comb begin
    s1_item_nxt.kind = kind_t'(in_if.kind);
    s1_item_nxt.x0   = pu[ProdBits-1:FracBits];
    s1_item_nxt.fu   = pu[FracBits-1:0];
    s1_item_nxt.y0   = pv[ProdBits-1:FracBits];
    s1_item_nxt.fv   = pv[FracBits-1:0];
    s1_item_nxt.col  = in_if.write_col;
    s1_item_nxt.row  = in_if.write_row;
    s1_item_nxt.rgb  = in_if.write_rgb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (q_push) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= s1_item_nxt;
    end
  end

endmodule

@@ rtl/bts_fifo.sv @@
// ----------------------------------------------------------------------------
// bts_fifo
// Short queue between the front and the back end.
// ----------------------------------------------------------------------------
module bts_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bts_pkg::item_t push_item,
  input  logic           pop,
  output bts_pkg::item_t pop_item,
  output logic           full,
  output logic           empty
);
  import bts_pkg::*;

  item_t                 buf_r [QDepth];
  logic [QPtrBits-1:0]   wp_r;
  logic [QPtrBits-1:0]   rp_r;
  logic [QPtrBits:0]     cnt_r;

  assign full     = (cnt_r == (QPtrBits+1)'(QDepth));
  assign empty    = (cnt_r == '0);
  assign pop_item = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + QPtrBits'(1);
      end
      if (pop) begin
        rp_r <= rp_r + QPtrBits'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (QPtrBits+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (QPtrBits+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= push_item;
    end
  end

endmodule

@@ rtl/bts_back.sv @@
// ----------------------------------------------------------------------------
// bts_back
// Wraps texel indices with a bit-per-stage modulo pipeline, reads the four
// texels from a duplicated store, blends them and registers the result.
// ----------------------------------------------------------------------------
module bts_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bts_pkg::SizeBits-1:0]  w_eff,
  input  logic [bts_pkg::SizeBits-1:0]  h_eff,
  input  logic                          q_empty,
  input  bts_pkg::item_t                q_item,
  output logic                          q_pop,
  bts_out_if.source                     out_if
);
  import bts_pkg::*;

  typedef struct packed {
    logic                 v;
    item_t                it;
    logic [WholeBits-1:0] mx;
    logic [WholeBits-1:0] my;
    logic [SizeBits-1:0]  rx;
    logic [SizeBits-1:0]  ry;
  } mod_t;

  localparam logic [WtBits-1:0]  One  = WtBits'(1) << FracBits;
  localparam logic [AccBits-1:0] Half = AccBits'(1) << (2*FracBits - 1);

  logic   adv;
  mod_t   st_r [WholeBits+1];
  mod_t   st0_nxt;

  // Address stage
  logic                 a_v_r;
  item_t                a_it_r;
  logic [ColBits-1:0]   a_c0_r, a_c1_r;
  logic [RowBits-1:0]   a_r0_r, a_r1_r;
  logic [SizeBits-1:0]  cx0, cx1, ym0, ym1, ry0, ry1;

  // Memory stage
  logic [RgbBits-1:0]   mem_a [Depth];
  logic [RgbBits-1:0]   mem_b [Depth];
  logic                 m_v_r;
  kind_t                m_kind_r;
  logic [FracBits-1:0]  m_fu_r, m_fv_r;
  logic [RgbBits-1:0]   t00_r, t10_r, t01_r, t11_r;

  // Blend stages
  logic                 b1_v_r;
  kind_t                b1_kind_r;
  logic [FracBits-1:0]  b1_fv_r;
  logic [TopBits-1:0]   top_r [3];
  logic [TopBits-1:0]   bot_r [3];
  logic [TopBits-1:0]   top_nxt [3];
  logic [TopBits-1:0]   bot_nxt [3];
  logic                 b2_v_r;
  kind_t                b2_kind_r;
  logic [AccBits-1:0]   pt_r [3];
  logic [AccBits-1:0]   pb_r [3];
  logic [ChanBits-1:0]  res_nxt [3];
  logic [AccBits-1:0]   sum [3];
  logic [WtBits-1:0]    wu, wv;

  logic                 out_v_r;
  logic [ChanBits-1:0]  res_r [3];

  function automatic logic [SizeBits-1:0] mod_step(logic [SizeBits-1:0] r, logic b,
                                                   logic [SizeBits-1:0] n);
    logic [SizeBits:0] t;
    t = {r, b};
    if (t >= {1'b0, n}) begin
      t = t - {1'b0, n};
    end
    return t[SizeBits-1:0];
  endfunction

  // The whole back end moves together whenever the result register can take data.
  assign adv   = !out_v_r || out_if.ready;
  assign q_pop = adv && !q_empty;

  always_comb begin
    st0_nxt.v  = q_pop;
    st0_nxt.it = q_item;
    st0_nxt.mx = q_item.x0[WholeBits-1] ? WholeBits'(-q_item.x0) : WholeBits'(q_item.x0);
    st0_nxt.my = q_item.y0[WholeBits-1] ? WholeBits'(-q_item.y0) : WholeBits'(q_item.y0);
    st0_nxt.rx = '0;
    st0_nxt.ry = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0].v <= 1'b0;
    end else if (adv) begin
      st_r[0] <= st0_nxt;
    end
  end

  // One remainder bit per stage, most significant bit of the magnitude first.
  for (genvar k = 0; k < WholeBits; k++) begin : g_mod
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k+1].v <= 1'b0;
      end else if (adv) begin
        st_r[k+1].v  <= st_r[k].v;
        st_r[k+1].it <= st_r[k].it;
        st_r[k+1].mx <= st_r[k].mx;
        st_r[k+1].my <= st_r[k].my;
        st_r[k+1].rx <= mod_step(st_r[k].rx, st_r[k].mx[WholeBits-1-k], w_eff);
        st_r[k+1].ry <= mod_step(st_r[k].ry, st_r[k].my[WholeBits-1-k], h_eff);
      end
    end
  end

  // A negative index wraps to size minus the remainder of its magnitude.
  always_comb begin
    cx0 = (st_r[WholeBits].it.x0[WholeBits-1] && st_r[WholeBits].rx != '0) ?
          w_eff - st_r[WholeBits].rx : st_r[WholeBits].rx;
    cx1 = (cx0 == w_eff - SizeBits'(1)) ? '0 : cx0 + SizeBits'(1);
    ym0 = (st_r[WholeBits].it.y0[WholeBits-1] && st_r[WholeBits].ry != '0) ?
          h_eff - st_r[WholeBits].ry : st_r[WholeBits].ry;
    ym1 = (ym0 == h_eff - SizeBits'(1)) ? '0 : ym0 + SizeBits'(1);
    ry0 = h_eff - SizeBits'(1) - ym0;
    ry1 = h_eff - SizeBits'(1) - ym1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= st_r[WholeBits].v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_it_r <= st_r[WholeBits].it;
      a_c0_r <= ColBits'(cx0);
      a_c1_r <= ColBits'(cx1);
      a_r0_r <= RowBits'(ry0);
      a_r1_r <= RowBits'(ry1);
    end
  end

  // Two store copies, each read at two columns: mem_a top row, mem_b bottom row.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (a_v_r && a_it_r.kind == KIND_WRITE) begin
        mem_a[{a_it_r.row, a_it_r.col}] <= a_it_r.rgb;
        mem_b[{a_it_r.row, a_it_r.col}] <= a_it_r.rgb;
      end
      t00_r <= mem_a[{a_r0_r, a_c0_r}];
      t10_r <= mem_a[{a_r0_r, a_c1_r}];
      t01_r <= mem_b[{a_r1_r, a_c0_r}];
      t11_r <= mem_b[{a_r1_r, a_c1_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r  <= 1'b0;
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r  <= a_v_r;
      b1_v_r <= m_v_r;
      b2_v_r <= b1_v_r;
    end
  end

  assign wu = One - WtBits'(m_fu_r);
  assign wv = One - WtBits'(b1_fv_r);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      top_nxt[ch] = TopBits'(t00_r[RgbBits-1-ChanBits*ch -: ChanBits]) * TopBits'(wu)
                  + TopBits'(t10_r[RgbBits-1-ChanBits*ch -: ChanBits]) * TopBits'(m_fu_r);
      bot_nxt[ch] = TopBits'(t01_r[RgbBits-1-ChanBits*ch -: ChanBits]) * TopBits'(wu)
                  + TopBits'(t11_r[RgbBits-1-ChanBits*ch -: ChanBits]) * TopBits'(m_fu_r);
      sum[ch]     = pt_r[ch] + pb_r[ch] + Half;
      res_nxt[ch] = sum[ch][2*FracBits +: ChanBits];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_kind_r  <= a_it_r.kind;
      m_fu_r    <= a_it_r.fu;
      m_fv_r    <= a_it_r.fv;
      b1_kind_r <= m_kind_r;
      b1_fv_r   <= m_fv_r;
      b2_kind_r <= b1_kind_r;
      for (int ch = 0; ch < 3; ch++) begin
        top_r[ch] <= top_nxt[ch];
        bot_r[ch] <= bot_nxt[ch];
        pt_r[ch]  <= AccBits'(top_r[ch]) * AccBits'(wv);
        pb_r[ch]  <= AccBits'(bot_r[ch]) * AccBits'(b1_fv_r);
        res_r[ch] <= res_nxt[ch];
      end
    end
  end

  // Writes travel the same path to keep order but produce no transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= b2_v_r && (b2_kind_r == KIND_SAMPLE);
    end
  end

  assign out_if.valid = out_v_r;
  assign out_if.red   = res_r[0];
  assign out_if.green = res_r[1];
  assign out_if.blue  = res_r[2];

endmodule

@@ rtl/bilinear_texture_sampler_top.sv @@
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_top
// Bilinear RGB888 texture sampler with repeat wrapping on both axes.
// ----------------------------------------------------------------------------
//  Channel   Dir   Payload                                     Handshake
//  in_if     in    kind, tex_u, tex_v, write_col/row/rgb       valid/ready
//  out_if    out   red, green, blue                            valid/ready
//  cfg_if    in    idx, data (tex_width, tex_height)           valid/ready
//
// One item is taken per cycle while the queue is not full. A sample result
// runs through the 24-stage modulo pipeline, the store read and the blend.
// Reset is synchronous and clears only control state; the texel store is not
// cleared and must be written before it is sampled. A stalled result holds the
// whole back end, and the four-entry queue lets the front keep accepting.
// The configuration port is always ready.
module bilinear_texture_sampler_top (
  input  logic       clk,
  input  logic       rst_n,
  bts_in_if.sink     in_if,
  bts_out_if.source  out_if,
  bts_cfg_if.sink    cfg_if
);
  import bts_pkg::*;

  logic [SizeBits-1:0] tex_width_r;
  logic [SizeBits-1:0] tex_height_r;
  logic [SizeBits-1:0] w_eff;
  logic [SizeBits-1:0] h_eff;
  logic                q_push, q_pop, q_full, q_empty;
  item_t               q_in_item, q_out_item;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= SizeBits'(1);
      tex_height_r <= SizeBits'(1);
    end else if (cfg_if.valid) begin
      unique case (cfg_if.idx)
        CFG_TEX_WIDTH:  tex_width_r  <= cfg_if.data;
        CFG_TEX_HEIGHT: tex_height_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  assign w_eff = eff_size(tex_width_r, SizeBits'(MaxW));
  assign h_eff = eff_size(tex_height_r, SizeBits'(MaxH));

  bts_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .w_eff  (w_eff),
    .h_eff  (h_eff),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in_item)
  );

  bts_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  bts_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .q_empty (q_empty),
    .q_item  (q_out_item),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty))
    else $error("queue read while empty");

  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    w_eff != '0 && w_eff <= SizeBits'(MaxW) && h_eff != '0 && h_eff <= SizeBits'(MaxH))
    else $error("effective texture size out of range");

endmodule
